>>> rtl/rgbhsl_pkg.sv
// shared constants and types for the rgb to hsl converter
package rgbhsl_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;
  localparam int LIGHT_W = 9;

  localparam int HUE_SIXTH = 3840;
  localparam int HUE_TURN = 23040;
  localparam int HUE_GREEN_BASE = 2 * HUE_SIXTH;
  localparam int HUE_BLUE_BASE = 4 * HUE_SIXTH;
  localparam int LIGHT_FULL = 510;
  localparam int LIGHT_HALF = 255;

  localparam int DIV_DEN_W = 8;
  localparam int DIV_QUO_W = 16;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = DIV_QUO_W / DIV_BITS_PER_STAGE;

  localparam int HUE_Q_W = 12;

  localparam int LATENCY = DIV_STAGES + 3;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

>>> rtl/rgbhsl_div.sv
// pipelined restoring divider, two quotient bits per stage
module rgbhsl_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [rgbhsl_pkg::DIV_NUM_W-1:0]   num,
  input  logic [rgbhsl_pkg::DIV_DEN_W-1:0]   den,
  output logic                               out_valid,
  output logic [rgbhsl_pkg::DIV_QUO_W-1:0]   quot,
  output logic                               rem_nz
);

  typedef struct packed {
    logic [rgbhsl_pkg::DIV_DEN_W-1:0] rem;
    logic [rgbhsl_pkg::DIV_QUO_W-1:0] low;
    logic [rgbhsl_pkg::DIV_QUO_W-1:0] quot;
    logic [rgbhsl_pkg::DIV_DEN_W-1:0] den;
  } div_stage_t;

  div_stage_t stage [rgbhsl_pkg::DIV_STAGES];
  div_stage_t stage_next [rgbhsl_pkg::DIV_STAGES];
  logic [rgbhsl_pkg::DIV_STAGES-1:0] valid;

  for (genvar i = 0; i < rgbhsl_pkg::DIV_STAGES; i++) begin : g_stage
    div_stage_t prev;

    if (i == 0) begin : g_first
      always_comb begin
        prev.rem = num[rgbhsl_pkg::DIV_NUM_W-1:rgbhsl_pkg::DIV_QUO_W];
        prev.low = num[rgbhsl_pkg::DIV_QUO_W-1:0];
        prev.quot = '0;
        prev.den = den;
      end
    end else begin : g_rest
      always_comb begin
        prev = stage[i-1];
      end
    end

    always_comb begin
      div_stage_t s;
      logic [rgbhsl_pkg::DIV_DEN_W:0] trial;
      logic qbit;
      s = prev;
      for (int k = 0; k < rgbhsl_pkg::DIV_BITS_PER_STAGE; k++) begin
        trial = {s.rem, s.low[rgbhsl_pkg::DIV_QUO_W-1]};
        qbit = (trial >= {1'b0, s.den});
        if (qbit) begin
          trial = trial - {1'b0, s.den};
        end
        s.rem = trial[rgbhsl_pkg::DIV_DEN_W-1:0];
        s.low = {s.low[rgbhsl_pkg::DIV_QUO_W-2:0], 1'b0};
        s.quot = {s.quot[rgbhsl_pkg::DIV_QUO_W-2:0], qbit};
      end
      stage_next[i] = s;
    end

    always_ff @(posedge clk) begin
      stage[i] <= stage_next[i];
      if (rst) begin
        valid[i] <= 1'b0;
      end else begin
        valid[i] <= (i == 0) ? in_valid : valid[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_valid = valid[rgbhsl_pkg::DIV_STAGES-1];
  assign quot = stage[rgbhsl_pkg::DIV_STAGES-1].quot;
  assign rem_nz = |stage[rgbhsl_pkg::DIV_STAGES-1].rem;

  // a word leaving the divider entered it and passed through every divider stage
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, rgbhsl_pkg::DIV_STAGES))
    else $error("divider output without matching input");

  // remainder always stays below a nonzero divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (stage[rgbhsl_pkg::DIV_STAGES-1].den != '0)) |->
      (stage[rgbhsl_pkg::DIV_STAGES-1].rem < stage[rgbhsl_pkg::DIV_STAGES-1].den))
    else $error("divider remainder out of range");

  // no word accepted before reset survives it
  a_div_flush: assert property (@(posedge clk)
    rst |=> (valid == '0))
    else $error("divider valid bits not cleared by reset");

endmodule

>>> rtl/rgb_to_hsl_converter.sv
// rgb to hsl converter top level: channel analysis, dividers and hue assembly
//
//  channel  | handshake           | fields
//  ---------+---------------------+---------------------------------------------
//  pixel in | start / busy        | red_in green_in blue_in alpha_in
//  hsl out  | done (one cycle)    | hue_out saturation_out lightness_out alpha_out
//
// one word per cycle; a word goes from start to done through two front stages,
// the 8-stage dividers (2 quotient bits per stage)
// and the output register
// busy stays low; the pipeline never stalls since results cannot be held off
// synchronous reset clears only the valid bits; words in flight are dropped
module rgb_to_hsl_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]     red_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]     green_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]     blue_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]     alpha_in,
  output logic                              done,
  output logic [rgbhsl_pkg::HUE_W-1:0]      hue_out,
  output logic [rgbhsl_pkg::SAT_W-1:0]      saturation_out,
  output logic [rgbhsl_pkg::LIGHT_W-1:0]    lightness_out,
  output logic [rgbhsl_pkg::CHAN_W-1:0]     alpha_out
);

  typedef struct packed {
    rgbhsl_pkg::sector_t                 sector;
    logic                                diff_neg;
    logic                                gray;
    logic [rgbhsl_pkg::LIGHT_W-1:0]      sum;
    logic [rgbhsl_pkg::CHAN_W-1:0]       alpha;
  } meta_t;

  typedef struct packed {
    meta_t                               meta;
    logic [rgbhsl_pkg::CHAN_W-1:0]       delta;
    logic [rgbhsl_pkg::CHAN_W-1:0]       den;
    logic [rgbhsl_pkg::CHAN_W-1:0]       diff_mag;
  } analyze_t;

  typedef struct packed {
    meta_t                               meta;
    logic [rgbhsl_pkg::CHAN_W-1:0]       delta;
    logic [rgbhsl_pkg::CHAN_W-1:0]       den;
    logic [rgbhsl_pkg::DIV_NUM_W-1:0]    sat_num;
    logic [rgbhsl_pkg::DIV_NUM_W-1:0]    hue_num;
  } numer_t;

  analyze_t s1;
  analyze_t s1_next;
  logic     s1_valid;
  numer_t   s2;
  numer_t   s2_next;
  logic     s2_valid;
  meta_t    meta_pipe [rgbhsl_pkg::DIV_STAGES];

  logic                               sat_valid;
  logic [rgbhsl_pkg::DIV_QUO_W-1:0]   sat_quot;
  logic                               sat_rem_nz;
  logic                               hue_valid;
  logic [rgbhsl_pkg::DIV_QUO_W-1:0]   hue_quot;
  logic                               hue_rem_nz;

  logic [rgbhsl_pkg::HUE_W-1:0]       hue_next;
  logic [rgbhsl_pkg::SAT_W-1:0]       sat_next;

  assign busy = 1'b0;

  // stage 1: max, min, sector, signed difference, lightness sum and saturation denominator
  always_comb begin
    logic [rgbhsl_pkg::CHAN_W-1:0] mx;
    logic [rgbhsl_pkg::CHAN_W-1:0] mn;
    logic [rgbhsl_pkg::CHAN_W:0]   diff;
    logic [rgbhsl_pkg::LIGHT_W-1:0] sum;
    logic [rgbhsl_pkg::LIGHT_W-1:0] far;
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx) mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    sum = {1'b0, mx} + {1'b0, mn};
    far = rgbhsl_pkg::LIGHT_W'(rgbhsl_pkg::LIGHT_FULL) - sum;
    if (red_in == mx) begin
      s1_next.meta.sector = rgbhsl_pkg::SECT_RED;
      diff = {1'b0, green_in} - {1'b0, blue_in};
    end else if (green_in == mx) begin
      s1_next.meta.sector = rgbhsl_pkg::SECT_GREEN;
      diff = {1'b0, blue_in} - {1'b0, red_in};
    end else begin
      s1_next.meta.sector = rgbhsl_pkg::SECT_BLUE;
      diff = {1'b0, red_in} - {1'b0, green_in};
    end
    s1_next.meta.diff_neg = diff[rgbhsl_pkg::CHAN_W];
    s1_next.diff_mag = diff[rgbhsl_pkg::CHAN_W] ?
      rgbhsl_pkg::CHAN_W'(-diff) : diff[rgbhsl_pkg::CHAN_W-1:0];
    s1_next.meta.gray = (mx == mn);
    s1_next.meta.sum = sum;
    s1_next.meta.alpha = alpha_in;
    s1_next.delta = mx - mn;
    s1_next.den = (sum <= rgbhsl_pkg::LIGHT_W'(rgbhsl_pkg::LIGHT_HALF)) ?
      sum[rgbhsl_pkg::CHAN_W-1:0] : far[rgbhsl_pkg::CHAN_W-1:0];
  end

  // stage 2: scaled numerators, delta*65535 and |diff|*3840
  always_comb begin
    s2_next.meta = s1.meta;
    s2_next.delta = s1.delta;
    s2_next.den = s1.den;
    s2_next.sat_num = {s1.delta, {rgbhsl_pkg::DIV_QUO_W{1'b0}}}
                      - rgbhsl_pkg::DIV_NUM_W'(s1.delta);
    s2_next.hue_num = (rgbhsl_pkg::DIV_NUM_W'(s1.diff_mag) << 12)
                      - (rgbhsl_pkg::DIV_NUM_W'(s1.diff_mag) << 8);
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
    end
  end

  rgbhsl_div u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .num       (s2.sat_num),
    .den       (s2.den),
    .out_valid (sat_valid),
    .quot      (sat_quot),
    .rem_nz    (sat_rem_nz)
  );

  rgbhsl_div u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .num       (s2.hue_num),
    .den       (s2.delta),
    .out_valid (hue_valid),
    .quot      (hue_quot),
    .rem_nz    (hue_rem_nz)
  );

  // side data rides alongside the dividers
  always_ff @(posedge clk) begin
    meta_pipe[0] <= s2.meta;
    for (int i = 1; i < rgbhsl_pkg::DIV_STAGES; i++) begin
      meta_pipe[i] <= meta_pipe[i-1];
    end
  end

  // final stage: hue assembly with floor toward minus infinity off the red sector
  always_comb begin
    meta_t m;
    logic [rgbhsl_pkg::HUE_W-1:0] base;
    logic [rgbhsl_pkg::HUE_W-1:0] hq;
    logic [rgbhsl_pkg::HUE_W-1:0] adj;
    m = meta_pipe[rgbhsl_pkg::DIV_STAGES-1];
    hq = rgbhsl_pkg::HUE_W'(hue_quot[rgbhsl_pkg::HUE_Q_W-1:0]);
    adj = '0;
    case (m.sector)
      rgbhsl_pkg::SECT_RED: begin
        base = m.diff_neg ? rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_TURN) : '0;
      end
      rgbhsl_pkg::SECT_GREEN: begin
        base = rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_GREEN_BASE);
        adj = rgbhsl_pkg::HUE_W'(hue_rem_nz);
      end
      rgbhsl_pkg::SECT_BLUE: begin
        base = rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_BLUE_BASE);
        adj = rgbhsl_pkg::HUE_W'(hue_rem_nz);
      end
      default: begin
        base = '0;
      end
    endcase
    if (m.gray) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = m.diff_neg ? (base - hq - adj) : (base + hq);
      sat_next = sat_quot;
    end
  end

  always_ff @(posedge clk) begin
    hue_out <= hue_next;
    saturation_out <= sat_next;
    lightness_out <= meta_pipe[rgbhsl_pkg::DIV_STAGES-1].sum;
    alpha_out <= meta_pipe[rgbhsl_pkg::DIV_STAGES-1].alpha;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sat_valid;
    end
  end

  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    sat_valid == hue_valid)
    else $error("divider valid bits out of step");

  // every result word comes from a pixel accepted on start while not busy
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rgbhsl_pkg::LATENCY))
    else $error("result word without matching pixel");

  // hue stays within one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue_out < rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_TURN)))
    else $error("hue out of range");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && (lightness_out == '0)) |-> ((hue_out == '0) && (saturation_out == '0)))
    else $error("black pixel with nonzero hue or saturation");

  // sector quotient never exceeds one sixth of a turn
  a_hue_quot: assert property (@(posedge clk) disable iff (rst)
    (hue_valid && !meta_pipe[rgbhsl_pkg::DIV_STAGES-1].gray) |->
      (hue_quot <= rgbhsl_pkg::DIV_QUO_W'(rgbhsl_pkg::HUE_SIXTH)))
    else $error("hue quotient above one sector");

  // gray pixel gives zero saturation; the saturation remainder is not used past the divider
  a_sat_gray: assert property (@(posedge clk) disable iff (rst)
    (sat_valid && meta_pipe[rgbhsl_pkg::DIV_STAGES-1].gray) |=> (saturation_out == '0))
    else $error("gray pixel with nonzero saturation");

  logic unused_sat_rem;
  assign unused_sat_rem = sat_rem_nz;

endmodule

>>> tb/rgb_to_hsl_checker.sv
// checker for the rgb to hsl converter: predicts each hsl word and compares it with the output
`timescale 1ns / 1ps
module rgb_to_hsl_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]  red_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]  green_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]  blue_in,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]  alpha_in,
  input  logic                           done,
  input  logic [rgbhsl_pkg::HUE_W-1:0]   hue_out,
  input  logic [rgbhsl_pkg::SAT_W-1:0]   saturation_out,
  input  logic [rgbhsl_pkg::LIGHT_W-1:0] lightness_out,
  input  logic [rgbhsl_pkg::CHAN_W-1:0]  alpha_out,
  output int                             fail_count,
  output int                             pending_words,
  output int                             checked_words
);

  localparam int SAT_FULL = 65535;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [rgbhsl_pkg::HUE_W-1:0]   hue;
    logic [rgbhsl_pkg::SAT_W-1:0]   sat;
    logic [rgbhsl_pkg::LIGHT_W-1:0] light;
    logic [rgbhsl_pkg::CHAN_W-1:0]  alpha;
  } hsl_word_t;

  hsl_word_t expected_hsl[$];
  int errors;
  int checks;

  function automatic hsl_word_t predict_hsl(input logic [rgbhsl_pkg::CHAN_W-1:0] r,
                                            input logic [rgbhsl_pkg::CHAN_W-1:0] g,
                                            input logic [rgbhsl_pkg::CHAN_W-1:0] b,
                                            input logic [rgbhsl_pkg::CHAN_W-1:0] a);
    hsl_word_t w;
    int ri, gi, bi, mx, mn, sum, delta, den, base, diff, hue;
    rgbhsl_pkg::sector_t sect;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    sum = mx + mn;
    hue = 0;
    w.sat = '0;
    if (mx != mn) begin
      delta = mx - mn;
      den = (sum <= rgbhsl_pkg::LIGHT_HALF) ? sum : rgbhsl_pkg::LIGHT_FULL - sum;
      w.sat = rgbhsl_pkg::SAT_W'((delta * SAT_FULL) / den);
      // red wins ties over green, green over blue
      if (ri == mx) sect = rgbhsl_pkg::SECT_RED;
      else if (gi == mx) sect = rgbhsl_pkg::SECT_GREEN;
      else sect = rgbhsl_pkg::SECT_BLUE;
      case (sect)
        rgbhsl_pkg::SECT_RED: begin
          base = 0;
          diff = gi - bi;
        end
        rgbhsl_pkg::SECT_GREEN: begin
          base = rgbhsl_pkg::HUE_GREEN_BASE;
          diff = bi - ri;
        end
        default: begin
          base = rgbhsl_pkg::HUE_BLUE_BASE;
          diff = ri - gi;
        end
      endcase
      hue = (base * delta + diff * rgbhsl_pkg::HUE_SIXTH) / delta;
      if (hue < 0) hue += rgbhsl_pkg::HUE_TURN;
    end
    w.hue = rgbhsl_pkg::HUE_W'(hue);
    w.light = rgbhsl_pkg::LIGHT_W'(sum);
    w.alpha = a;
    return w;
  endfunction

  always @(posedge clk) begin
    hsl_word_t want;
    if (rst) begin
      expected_hsl.delete();
    end else begin
      if (start && !busy) begin
        expected_hsl.push_back(predict_hsl(red_in, green_in, blue_in, alpha_in));
      end
      if (done) begin
        checks++;
        if (expected_hsl.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: hsl word with none expected: hue %0d sat %0d light %0d alpha %0d",
                     $realtime, hue_out, saturation_out, lightness_out, alpha_out);
          end
        end else begin
          want = expected_hsl.pop_front();
          if (hue_out !== want.hue || saturation_out !== want.sat ||
              lightness_out !== want.light || alpha_out !== want.alpha) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: hsl mismatch exp hue %0d sat %0d light %0d alpha %0d", $realtime,
                       want.hue, want.sat, want.light, want.alpha);
              $display("%0t:              got hue %0d sat %0d light %0d alpha %0d", $realtime,
                       hue_out, saturation_out, lightness_out, alpha_out);
            end
          end
        end
      end
    end
    fail_count <= errors;
    pending_words <= expected_hsl.size();
    checked_words <= checks;
  end

endmodule

>>> tb/rgb_to_hsl_converter_tb.sv
// testbench top for the rgb to hsl converter: clock, reset, pixel stimulus and verdict
`timescale 1ns / 1ps
module rgb_to_hsl_converter_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int WORDS_PER_PHASE = 460;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic [rgbhsl_pkg::CHAN_W-1:0]   red_in;
  logic [rgbhsl_pkg::CHAN_W-1:0]   green_in;
  logic [rgbhsl_pkg::CHAN_W-1:0]   blue_in;
  logic [rgbhsl_pkg::CHAN_W-1:0]   alpha_in;
  logic                            done;
  logic [rgbhsl_pkg::HUE_W-1:0]    hue_out;
  logic [rgbhsl_pkg::SAT_W-1:0]    saturation_out;
  logic [rgbhsl_pkg::LIGHT_W-1:0]  lightness_out;
  logic [rgbhsl_pkg::CHAN_W-1:0]   alpha_out;

  int fail_count;
  int pending_words;
  int checked_words;
  int cycle_count;
  int idle_pct;
  int words_sent;
  int gray_words;
  int tie_words;

  rgb_to_hsl_converter uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .done(done), .hue_out(hue_out), .saturation_out(saturation_out),
    .lightness_out(lightness_out), .alpha_out(alpha_out)
  );

  rgb_to_hsl_checker hsl_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .done(done), .hue_out(hue_out), .saturation_out(saturation_out),
    .lightness_out(lightness_out), .alpha_out(alpha_out),
    .fail_count(fail_count), .pending_words(pending_words), .checked_words(checked_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending_words);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input logic [rgbhsl_pkg::CHAN_W-1:0] r,
                            input logic [rgbhsl_pkg::CHAN_W-1:0] g,
                            input logic [rgbhsl_pkg::CHAN_W-1:0] b,
                            input logic [rgbhsl_pkg::CHAN_W-1:0] a);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    alpha_in <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (r == g && g == b) gray_words++;
    else if (r == g || g == b || r == b) tie_words++;
  endtask

  task automatic drain_words();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  function automatic logic [rgbhsl_pkg::CHAN_W-1:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [rgbhsl_pkg::CHAN_W-1:0] r, g, b, v;
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      r = rgbhsl_pkg::CHAN_W'($urandom);
      g = rgbhsl_pkg::CHAN_W'($urandom);
      b = rgbhsl_pkg::CHAN_W'($urandom);
      v = rgbhsl_pkg::CHAN_W'($urandom);
      if (kind < 12) begin
        r = v;
        g = v;
        b = v;
      end else if (kind < 30) begin
        // two channels equal, to exercise the max and min tie rules
        case ($urandom_range(0, 2))
          0: begin
            r = v;
            g = v;
          end
          1: begin
            g = v;
            b = v;
          end
          default: begin
            r = v;
            b = v;
          end
        endcase
      end else if (kind < 42) begin
        r = edge_value();
        g = edge_value();
        b = edge_value();
      end
      send_pixel(r, g, b, rgbhsl_pkg::CHAN_W'($urandom));
    end
  endtask

  initial begin
    words_sent = 0;
    gray_words = 0;
    tie_words = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    alpha_in = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pixels: extremes, primaries, ties, gray and the lightness knee
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'hAA);
    send_pixel(8'd255, 8'd0, 8'd0, 8'h55);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd17);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd33);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd66);
    send_pixel(8'd255, 8'd0, 8'd10, 8'd99);
    send_pixel(8'd200, 8'd55, 8'd100, 8'd128);
    send_pixel(8'd200, 8'd56, 8'd100, 8'd127);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd200);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd3);
    send_pixel(8'd0, 8'd1, 8'd1, 8'd250);
    send_pixel(8'd254, 8'd255, 8'd255, 8'd8);
    send_pixel(8'd10, 8'd200, 8'd200, 8'd64);
    send_pixel(8'd50, 8'd100, 8'd150, 8'd192);
    send_pixel(8'd150, 8'd100, 8'd50, 8'd240);
    send_pixel(8'd100, 8'd50, 8'd150, 8'd15);
    send_pixel(8'd128, 8'd127, 8'd127, 8'd7);
    send_pixel(8'd127, 8'd128, 8'd0, 8'd248);
    drain_words();

    idle_pct = 11;
    send_random(WORDS_PER_PHASE);
    drain_words();
    idle_pct = 84;
    send_random(WORDS_PER_PHASE);
    drain_words();
    idle_pct = 0;
    send_random(WORDS_PER_PHASE);
    drain_words();
    repeat (rgbhsl_pkg::LATENCY + 5) @(posedge clk);

    $display("sent %0d pixels (%0d gray, %0d with tied channels), checked %0d hsl words",
             words_sent, gray_words, tie_words, checked_words);
    $display("pacing ran with sender gaps at 11 and 84 percent and back to back");
    if (fail_count == 0 && pending_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures, %0d words missing", fail_count, pending_words);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_div.sv
rtl/rgb_to_hsl_converter.sv
tb/rgb_to_hsl_checker.sv
tb/rgb_to_hsl_converter_tb.sv
